// ===== sv/ihp_pkg.sv =====
`timescale 1ns / 1ps

package ihp_pkg;

  // Histogram geometry
  localparam int COUNT_BITS = 32;
  localparam int NUM_BINS   = 256;
  localparam int BIN_BITS   = $clog2(NUM_BINS);

  // Port field widths
  localparam int PIX_BITS  = 8;
  localparam int OUT_BITS  = 32;
  localparam int MODE_BITS = 3;
  localparam int OP_BITS   = 2;

  // Luma weights over 100, and floor(x / 100) as (x * RECIP) >> RECIP_SHIFT,
  // exact for every weighted sum up to 30*255 + 59*255 + 11*255 = 25500
  localparam int SUM_BITS    = 15;
  localparam int W_RED       = 30;
  localparam int W_GREEN     = 59;
  localparam int W_BLUE      = 11;
  localparam int RECIP       = 5243;
  localparam int RECIP_BITS  = 13;
  localparam int RECIP_SHIFT = 19;

  // Channel mode codes
  localparam logic [MODE_BITS-1:0] MODE_GRAY  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_LUMA  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_RED   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_GREEN = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_BLUE  = 3'd4;

  typedef enum logic [OP_BITS-1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIN,
    S_READ,
    S_WRITE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic bin_en;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } ctrl_sts_t;

endpackage

// ===== sv/ihp_if.sv =====
`timescale 1ns / 1ps

interface ihp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ihp_pkg::OP_BITS-1:0]  op;
  logic [ihp_pkg::PIX_BITS-1:0] gray_or_red;
  logic [ihp_pkg::PIX_BITS-1:0] green_value;
  logic [ihp_pkg::PIX_BITS-1:0] blue_value;
  logic [ihp_pkg::BIN_BITS-1:0] bin_select;

  modport source (output valid, op, gray_or_red, green_value, blue_value, bin_select,
                  input ready);
  modport sink   (input valid, op, gray_or_red, green_value, blue_value, bin_select,
                  output ready);
endinterface

interface ihp_out_if;
  logic                         valid;
  logic                         ready;
  logic [ihp_pkg::OUT_BITS-1:0] bin_count;
  logic [ihp_pkg::OUT_BITS-1:0] max_height;
  logic [ihp_pkg::BIN_BITS-1:0] peak_bin;

  modport source (output valid, bin_count, max_height, peak_bin, input ready);
  modport sink   (input valid, bin_count, max_height, peak_bin, output ready);
endinterface

// ===== sv/ihp_ctrl.sv =====
`timescale 1ns / 1ps

module ihp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ihp_pkg::ctrl_sts_t sts,
  output ihp_pkg::ctrl_cmd_t cmd
);

  ihp_pkg::state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ihp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ihp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ihp_pkg::S_BIN;
      end
      ihp_pkg::S_BIN:   state_nxt = ihp_pkg::S_READ;
      ihp_pkg::S_READ:  state_nxt = ihp_pkg::S_WRITE;
      ihp_pkg::S_WRITE: begin
        // hold until the output register can take the result
        if (!sts.out_busy) state_nxt = ihp_pkg::S_IDLE;
      end
      default: state_nxt = ihp_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ihp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ihp_pkg::S_BIN:   cmd.bin_en = 1'b1;
      ihp_pkg::S_READ:  cmd.rd_en  = 1'b1;
      ihp_pkg::S_WRITE: cmd.commit = !sts.out_busy;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/ihp_datapath.sv =====
`timescale 1ns / 1ps

module ihp_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item fields
  input  logic [ihp_pkg::OP_BITS-1:0]   in_op,
  input  logic [ihp_pkg::PIX_BITS-1:0]  in_gray_or_red,
  input  logic [ihp_pkg::PIX_BITS-1:0]  in_green_value,
  input  logic [ihp_pkg::PIX_BITS-1:0]  in_blue_value,
  input  logic [ihp_pkg::BIN_BITS-1:0]  in_bin_select,
  // configuration
  input  logic                          cfg_we,
  input  logic [ihp_pkg::MODE_BITS-1:0] cfg_wdata,
  // control
  input  ihp_pkg::ctrl_cmd_t            cmd,
  output ihp_pkg::ctrl_sts_t            sts,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ihp_pkg::OUT_BITS-1:0]  out_bin_count,
  output logic [ihp_pkg::OUT_BITS-1:0]  out_max_height,
  output logic [ihp_pkg::BIN_BITS-1:0]  out_peak_bin
);

  localparam int CB = ihp_pkg::COUNT_BITS;
  localparam int OB = ihp_pkg::OUT_BITS;
  localparam int BB = ihp_pkg::BIN_BITS;
  localparam int SB = ihp_pkg::SUM_BITS;
  localparam int RB = ihp_pkg::RECIP_BITS;

  logic [ihp_pkg::MODE_BITS-1:0] mode_r;
  ihp_pkg::op_t                  op_r;
  logic [ihp_pkg::PIX_BITS-1:0]  red_r, green_r, blue_r;
  logic [BB-1:0]                 sel_r, bin_r;
  logic [SB-1:0]                 sum_r;
  logic [SB-1:0]                 sum_nxt;
  logic [SB+RB-1:0]              luma_prod;
  logic [BB-1:0]                 bin_nxt;
  logic [BB-1:0]                 rd_addr;

  logic [CB-1:0]                 mem [ihp_pkg::NUM_BINS];
  logic [ihp_pkg::NUM_BINS-1:0]  valid_r;
  logic [CB-1:0]                 rd_data_r;
  logic                          rd_valid_r;

  logic [CB-1:0]                 count_cur, count_inc;
  logic [CB-1:0]                 tallest_r, tallest_nxt;
  logic [BB-1:0]                 peak_idx_r, peak_idx_nxt;
  logic [OB+CB-1:0]              cur_ext, tallest_ext;
  logic [OB-1:0]                 read_val;

  logic                          out_valid_r;
  logic [OB-1:0]                 bin_count_r, max_height_r;
  logic [BB-1:0]                 peak_bin_r;

  // Channel mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ihp_pkg::MODE_GRAY;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Weighted luma sum, taken straight from the input item
  assign sum_nxt = SB'(ihp_pkg::W_RED)   * SB'(in_gray_or_red)
                 + SB'(ihp_pkg::W_GREEN) * SB'(in_green_value)
                 + SB'(ihp_pkg::W_BLUE)  * SB'(in_blue_value);

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= ihp_pkg::op_t'(in_op);
      red_r   <= in_gray_or_red;
      green_r <= in_green_value;
      blue_r  <= in_blue_value;
      sel_r   <= in_bin_select;
      sum_r   <= sum_nxt;
    end
  end

  // Divide the sum by 100 through the reciprocal
  assign luma_prod = (SB+RB)'(sum_r) * (SB+RB)'(ihp_pkg::RECIP);

  // Pick the bin from the channel mode
  always_comb begin
    case (mode_r)
      ihp_pkg::MODE_LUMA:  bin_nxt = luma_prod[ihp_pkg::RECIP_SHIFT +: BB];
      ihp_pkg::MODE_RED:   bin_nxt = red_r;
      ihp_pkg::MODE_GREEN: bin_nxt = green_r;
      ihp_pkg::MODE_BLUE:  bin_nxt = blue_r;
      default:             bin_nxt = red_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_en) bin_r <= bin_nxt;
  end

  // Read the counter store; an entry without its valid bit counts as zero
  assign rd_addr = (op_r == ihp_pkg::OP_READ) ? sel_r : bin_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign count_cur = rd_valid_r ? rd_data_r : '0;
  assign count_inc = (count_cur == {CB{1'b1}}) ? count_cur : count_cur + CB'(1);

  // Write back the incremented counter
  always_ff @(posedge clk) begin
    if (cmd.commit && op_r == ihp_pkg::OP_ACCUM) begin
      mem[bin_r] <= count_inc;
    end
  end

  // Valid bits: set on write, dropped all at once on clear and reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (op_r == ihp_pkg::OP_CLEAR) begin
        valid_r <= '0;
      end else if (op_r == ihp_pkg::OP_ACCUM) begin
        valid_r[bin_r] <= 1'b1;
      end
    end
  end

  // Peak tracking, lowest index wins a tie
  always_comb begin
    tallest_nxt  = tallest_r;
    peak_idx_nxt = peak_idx_r;
    case (op_r)
      ihp_pkg::OP_ACCUM: begin
        if (count_inc > tallest_r) begin
          tallest_nxt  = count_inc;
          peak_idx_nxt = bin_r;
        end else if (count_inc == tallest_r && bin_r < peak_idx_r) begin
          peak_idx_nxt = bin_r;
        end
      end
      ihp_pkg::OP_CLEAR: begin
        tallest_nxt  = '0;
        peak_idx_nxt = '0;
      end
      default: begin
        tallest_nxt  = tallest_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tallest_r  <= '0;
      peak_idx_r <= '0;
    end else if (cmd.commit) begin
      tallest_r  <= tallest_nxt;
      peak_idx_r <= peak_idx_nxt;
    end
  end

  // Low bits of the counters for the result fields
  assign cur_ext     = {{OB{1'b0}}, count_cur};
  assign tallest_ext = {{OB{1'b0}}, tallest_nxt};
  assign read_val    = (op_r == ihp_pkg::OP_READ) ? cur_ext[OB-1:0] : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      bin_count_r  <= read_val;
      max_height_r <= tallest_ext[OB-1:0];
      peak_bin_r   <= peak_idx_nxt;
    end
  end

  assign sts.out_busy   = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_bin_count  = bin_count_r;
  assign out_max_height = max_height_r;
  assign out_peak_bin   = peak_bin_r;

endmodule

// ===== sv/image_histogram_with_peak.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// in_ch     in   valid / ready       op, gray_or_red, green_value, blue_value, bin_select
// out_ch    out  valid / ready       bin_count, max_height, peak_bin
// cfg       in   cfg_we (no ready)   cfg_wdata = channel_mode
//
// Each item passes through the steps accept, bin select (luma reciprocal multiply),
// counter RAM read, then update and write back; the single-port counter RAM
// read-modify-write keeps read and write in separate steps. A stalled output holds the last step.
// The next item is accepted while the previous result waits in the output register.
// Reset (rst_n, synchronous) and the clear op drop the per-bin valid bits at once;
// there is no clearing pass.

module image_histogram_with_peak (
  input  logic                          clk,
  input  logic                          rst_n,
  ihp_in_if.sink                        in_ch,
  ihp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ihp_pkg::MODE_BITS-1:0] cfg_wdata
);

  ihp_pkg::ctrl_cmd_t cmd;
  ihp_pkg::ctrl_sts_t sts;

  ihp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ihp_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_ch.op),
    .in_gray_or_red (in_ch.gray_or_red),
    .in_green_value (in_ch.green_value),
    .in_blue_value  (in_ch.blue_value),
    .in_bin_select  (in_ch.bin_select),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_bin_count  (out_ch.bin_count),
    .out_max_height (out_ch.max_height),
    .out_peak_bin   (out_ch.peak_bin)
  );

  // An accepted item moves on to bin selection
  a_accept_to_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> cmd.bin_en)
    else $error("accepted item did not reach bin selection");

  // A result appears only after a commit
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.commit))
    else $error("result shown without a commit");

  // Never overwrite a result still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_ch.valid && !out_ch.ready))
    else $error("commit while output register is stalled");

endmodule
